// ----- rtl/core/fxa_pkg.sv -----
// Package with the opcode, status and beat types of the Q24.8 fixed-point ALU.
`default_nettype none
package fxa_pkg;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_LT   = 4'd4,
      OP_GT   = 4'd5,
      OP_LE   = 4'd6,
      OP_GE   = 4'd7,
      OP_EQ   = 4'd8,
      OP_NE   = 4'd9,
      OP_MIN  = 4'd10,
      OP_MAX  = 4'd11,
      OP_INC  = 4'd12,
      OP_DEC  = 4'd13,
      OP_ITOF = 4'd14,
      OP_FTOI = 4'd15
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               truth;
      logic [1:0]         status;
   } rsp_type;

   // One pipeline slot. The work word holds the product for multiply and the
   // shifting dividend for divide.
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        neg;
      logic [31:0] mag_b;
      logic [31:0] simple_res;
      logic        truth;
      logic [1:0]  status;
      logic [63:0] work;
      logic [31:0] rem;
      logic [63:0] quo;
   } stage_type;

endpackage
`default_nettype wire

// ----- rtl/core/fxa_front.sv -----
// Input stage: decodes a request beat, does the plain opcodes and the multiply.
`default_nettype none
module fxa_front #(
   parameter int FRAC_WIDTH = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  wire fxa_pkg::req_type req,
   output fxa_pkg::stage_type   stage_out
);
   fxa_pkg::stage_type stage_ff, stage_in;
   logic signed [31:0] a, b;
   logic [31:0] ua, ub, mag_a, mag_b;

   always_comb begin
      a = req.operand_a;
      b = req.operand_b;
      ua = a;
      ub = b;
      mag_a = a[31] ? (~ua + 32'd1) : ua;
      mag_b = b[31] ? (~ub + 32'd1) : ub;
      stage_in = '0;
      stage_in.valid = accept;
      stage_in.op = req.op;
      stage_in.neg = a[31] ^ b[31];
      stage_in.mag_b = mag_b;
      stage_in.status = fxa_pkg::ST_OK;
      case (req.op)
         fxa_pkg::OP_ADD:  stage_in.simple_res = ua + ub;
         fxa_pkg::OP_SUB:  stage_in.simple_res = ua - ub;
         fxa_pkg::OP_MUL:  stage_in.work = mag_a * mag_b;
         fxa_pkg::OP_DIV: begin
            stage_in.work = {32'd0, mag_a} << FRAC_WIDTH;
            if (mag_b == 32'd0) stage_in.status = fxa_pkg::ST_DIV0;
         end
         fxa_pkg::OP_LT:   stage_in.truth = a < b;
         fxa_pkg::OP_GT:   stage_in.truth = a > b;
         fxa_pkg::OP_LE:   stage_in.truth = a <= b;
         fxa_pkg::OP_GE:   stage_in.truth = a >= b;
         fxa_pkg::OP_EQ:   stage_in.truth = a == b;
         fxa_pkg::OP_NE:   stage_in.truth = a != b;
         fxa_pkg::OP_MIN:  stage_in.simple_res = (a > b) ? ub : ua;
         fxa_pkg::OP_MAX:  stage_in.simple_res = (a > b) ? ua : ub;
         fxa_pkg::OP_INC:  stage_in.simple_res = ua + 32'd1;
         fxa_pkg::OP_DEC:  stage_in.simple_res = ua - 32'd1;
         fxa_pkg::OP_ITOF: stage_in.simple_res = ua << FRAC_WIDTH;
         fxa_pkg::OP_FTOI: stage_in.simple_res = 32'(a >>> FRAC_WIDTH);
         default:          stage_in.simple_res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) stage_ff.valid <= 1'b0;
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

// ----- rtl/core/fxa_div_cell.sv -----
// One cell of the divider chain: one restoring step that yields one quotient bit.
`default_nettype none
module fxa_div_cell #(
   parameter int FRAC_WIDTH = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire fxa_pkg::stage_type stage_prev,
   output fxa_pkg::stage_type     stage_out
);
   localparam int NW = 32 + FRAC_WIDTH;

   fxa_pkg::stage_type stage_ff, stage_in;
   logic [32:0] trial, diff;

   always_comb begin
      stage_in = stage_prev;
      trial = {stage_prev.rem, stage_prev.work[NW-1]};
      diff = trial - {1'b0, stage_prev.mag_b};
      if (stage_prev.op == fxa_pkg::OP_DIV) begin
         stage_in.work = stage_prev.work << 1;
         if (trial >= {1'b0, stage_prev.mag_b}) begin
            stage_in.rem = diff[31:0];
            stage_in.quo = {stage_prev.quo[62:0], 1'b1};
         end else begin
            stage_in.rem = trial[31:0];
            stage_in.quo = {stage_prev.quo[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) stage_ff.valid <= 1'b0;
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

// ----- rtl/core/fxa_round.sv -----
// Output stage: rounds half away from zero, saturates, and registers the result beat.
`default_nettype none
module fxa_round #(
   parameter int FRAC_WIDTH = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire fxa_pkg::stage_type stage_last,
   output logic                   rsp_valid,
   output fxa_pkg::rsp_type       rsp
);
   localparam logic [63:0] HALF = (FRAC_WIDTH > 0) ? (64'd1 << (FRAC_WIDTH - 1)) : 64'd0;

   fxa_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic [63:0] mag;
   logic round_up;

   always_comb begin
      round_up = {stage_last.rem, 1'b0} >= {1'b0, stage_last.mag_b};
      if (stage_last.op == fxa_pkg::OP_DIV) mag = stage_last.quo + {63'd0, round_up};
      else mag = (stage_last.work + HALF) >> FRAC_WIDTH;

      rsp_in.result_value = stage_last.simple_res;
      rsp_in.truth = stage_last.truth;
      rsp_in.status = stage_last.status;
      if ((stage_last.op == fxa_pkg::OP_MUL || stage_last.op == fxa_pkg::OP_DIV)
          && stage_last.status != fxa_pkg::ST_DIV0) begin
         if (stage_last.neg) begin
            if (mag > 64'h8000_0000) begin
               rsp_in.result_value = 32'h8000_0000;
               rsp_in.status = fxa_pkg::ST_OVF;
            end else begin
               rsp_in.result_value = ~mag[31:0] + 32'd1;
            end
         end else if (mag > 64'h7FFF_FFFF) begin
            rsp_in.result_value = 32'h7FFF_FFFF;
            rsp_in.status = fxa_pkg::ST_OVF;
         end else begin
            rsp_in.result_value = mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= stage_last.valid;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/core/fixed_point_q24_8_alu_core.sv -----
// A start passes the front, divider cell and round registers to rsp_valid (Q24.8 by default).
// Throughput: one beat every cycle; busy stays low because the pipeline never stalls.
// The divider is a chain of 32 + FRAC_WIDTH cells, one quotient bit per cell, setting the latency.
// All opcodes travel the same chain so results leave in order; the receiver cannot stall.
// Reset clears the valid bits of every stage; payload registers are not reset.
`default_nettype none
module fixed_point_q24_8_alu_core #(
   parameter int FRAC_WIDTH = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire fxa_pkg::req_type  req,
   output logic                   rsp_valid,
   output fxa_pkg::rsp_type       rsp
);
   localparam int NW = 32 + FRAC_WIDTH;
   localparam int LAT = NW + 2;

   fxa_pkg::stage_type chain [NW+1];

   assign busy = 1'b0;

   fxa_front #(.FRAC_WIDTH(FRAC_WIDTH)) u_front (
      .clock(clock), .reset(reset), .accept(start & ~busy), .req(req), .stage_out(chain[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fxa_div_cell #(.FRAC_WIDTH(FRAC_WIDTH)) u_cell (
         .clock(clock), .reset(reset), .stage_prev(chain[i]), .stage_out(chain[i+1])
      );
   end

   fxa_round #(.FRAC_WIDTH(FRAC_WIDTH)) u_round (
      .clock(clock), .reset(reset), .stage_last(chain[NW]), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid) else $error("result beat missing after start");
   a_div0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == fxa_pkg::ST_DIV0) |-> rsp.result_value == 32'sd0)
      else $error("division by zero must return zero");
   a_truth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.truth) |-> (rsp.result_value == 32'sd0 && rsp.status == fxa_pkg::ST_OK))
      else $error("comparison result must be zero with ok status");
endmodule
`default_nettype wire

// ----- sim/fixed_point_q24_8_alu_core_test.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU core.
module fixed_point_q24_8_alu_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 8;
   localparam int LATENCY = 34 + FRAC;

   class alu_scoreboard;
      fxa_pkg::rsp_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // Applies the sign to a magnitude and clamps it to 32 bits.
      function automatic fxa_pkg::rsp_type clamp(logic [63:0] m, bit neg);
         fxa_pkg::rsp_type r;
         r = '0;
         if (neg) begin
            if (m > 64'h8000_0000) begin
               r.result_value = 32'h8000_0000;
               r.status = fxa_pkg::ST_OVF;
            end else begin
               r.result_value = 32'(64'd0 - m);
            end
         end else if (m > 64'h7FFF_FFFF) begin
            r.result_value = 32'h7FFF_FFFF;
            r.status = fxa_pkg::ST_OVF;
         end else begin
            r.result_value = m[31:0];
         end
         return r;
      endfunction

      function automatic fxa_pkg::rsp_type compute(fxa_pkg::req_type q);
         fxa_pkg::rsp_type r;
         logic signed [31:0] a, b;
         logic [63:0] ma, mb, p, n, quo, rem;
         bit neg;
         r = '0;
         a = q.operand_a;
         b = q.operand_b;
         ma = a < 0 ? 64'(-64'(a)) : 64'(a);
         mb = b < 0 ? 64'(-64'(b)) : 64'(b);
         neg = (a < 0) != (b < 0);
         case (q.op)
            fxa_pkg::OP_ADD: r.result_value = a + b;
            fxa_pkg::OP_SUB: r.result_value = a - b;
            fxa_pkg::OP_MUL: begin
               p = ma * mb;
               r = clamp((p + (64'd1 << (FRAC - 1))) >> FRAC, neg);
            end
            fxa_pkg::OP_DIV: begin
               if (b == 0) begin
                  r.status = fxa_pkg::ST_DIV0;
               end else begin
                  n = ma << FRAC;
                  quo = n / mb;
                  rem = n % mb;
                  if (2 * rem >= mb) quo = quo + 1;
                  r = clamp(quo, neg);
               end
            end
            fxa_pkg::OP_LT: r.truth = a < b;
            fxa_pkg::OP_GT: r.truth = a > b;
            fxa_pkg::OP_LE: r.truth = a <= b;
            fxa_pkg::OP_GE: r.truth = a >= b;
            fxa_pkg::OP_EQ: r.truth = a == b;
            fxa_pkg::OP_NE: r.truth = a != b;
            fxa_pkg::OP_MIN: r.result_value = (a > b) ? b : a;
            fxa_pkg::OP_MAX: r.result_value = (a > b) ? a : b;
            fxa_pkg::OP_INC: r.result_value = a + 1;
            fxa_pkg::OP_DEC: r.result_value = a - 1;
            fxa_pkg::OP_ITOF: r.result_value = a <<< FRAC;
            default: r.result_value = a >>> FRAC;
         endcase
         return r;
      endfunction

      function void note_request(fxa_pkg::req_type q);
         pending.push_back(compute(q));
      endfunction

      function void check_result(fxa_pkg::rsp_type got);
         fxa_pkg::rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.result_value !== exp.result_value) begin
            $error("result_value expected %h actual %h", exp.result_value, got.result_value);
            errors++;
         end
         if (got.truth !== exp.truth) begin
            $error("truth expected %b actual %b", exp.truth, got.truth);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status expected %d actual %d", exp.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   fxa_pkg::req_type req = '0;
   logic busy, rsp_valid;
   fxa_pkg::rsp_type rsp;
   alu_scoreboard board = new();

   fixed_point_q24_8_alu_core #(.FRAC_WIDTH(FRAC)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp);
      if (!reset && start && !busy) board.note_request(req);
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: return 32'(int'($urandom_range(0, 4096)) - 2048);
         4: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
         default: return $urandom();
      endcase
   endfunction

   // Holds one beat on the request port until the block takes it.
   task automatic send_beat(fxa_pkg::op_type op, logic [31:0] a, logic [31:0] b);
      int gap;
      req <= '{op: op, operand_a: a, operand_b: b};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int wait_cycles;
      logic [31:0] edge_vals [6];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h100, 32'hFFFF_FF00, 32'd1};
      for (int k = 0; k < 16; k++) begin
         send_beat(fxa_pkg::op_type'(k), edge_vals[k % 6], edge_vals[(k + 1) % 6]);
      end
      send_beat(fxa_pkg::OP_DIV, 32'h1234, 32'd0);
      send_beat(fxa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(fxa_pkg::OP_MUL, 32'h8000_0000, 32'h100);
      send_beat(fxa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
      send_beat(fxa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd1);
      send_beat(fxa_pkg::OP_MUL, 32'h80, 32'h1);
      send_beat(fxa_pkg::OP_MUL, 32'hFFFF_FF80, 32'h1);
      send_beat(fxa_pkg::OP_EQ, 32'h55, 32'h55);
      send_beat(fxa_pkg::OP_FTOI, 32'hFFFF_FFFF, 32'd0);
      for (int k = 0; k < 1550; k++) begin
         send_beat(fxa_pkg::op_type'($urandom_range(0, 15)), pick_value(), pick_value());
      end
      start <= 1'b0;
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (board.pending.size() != 0) $error("%0d results never arrived", board.pending.size());
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/core/fxa_pkg.sv
rtl/core/fxa_front.sv
rtl/core/fxa_div_cell.sv
rtl/core/fxa_round.sv
rtl/core/fixed_point_q24_8_alu_core.sv
sim/fixed_point_q24_8_alu_core_test.sv
